@@ rtl/pdith_pkg.sv @@
// Shared types, constants and a helper function for the palette dither unit.
`timescale 1ns / 1ps
package pdith_pkg;

	localparam int          RW_BITS       = 11;
	localparam int          PS_BITS       = 5;
	localparam logic [10:0] ROW_WIDTH_RST = 11'd640;
	localparam logic [4:0]  PAL_SIZE_RST  = 5'd16;
	localparam logic [18:0] DIST_INIT     = 19'd300000;

	localparam logic REG_ROW_WIDTH = 1'b0;
	localparam logic REG_PAL_SIZE  = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_PIXEL = 2'd1,
		OP_FLUSH = 2'd2,
		OP_RSVD  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RDP_NONE,
		RDP_A,
		RDP_B,
		RDP_F
	} rd_phase_t;

	typedef enum logic [1:0] {
		WRP_NONE,
		WRP_0,
		WRP_1,
		WRP_2
	} wr_phase_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_PAL,
		S_RD0,
		S_RD1,
		S_RD2,
		S_SRCH,
		S_W0,
		S_W1,
		S_W2,
		S_FRD,
		S_FCAP,
		S_EMA,
		S_EMB,
		S_COPY
	} state_t;

	typedef struct packed {
		logic      latch;
		logic      pal_we;
		rd_phase_t rd_phase;
		logic      cap_a;
		logic      cap_b;
		logic      cap_f;
		logic      srch_start;
		logic      srch_run;
		wr_phase_t wr_phase;
		logic      copy_start;
		logic      copy_run;
		logic      out_b;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic first;
		logic act;
		logic quant;
		logic last;
		logic idx_ok;
		logic srch_done;
		logic copy_done;
	} status_t;

	function automatic logic [7:0] spread(input logic [7:0] v, input logic [2:0] k,
			input logic signed [8:0] e);
		logic signed [12:0] kx;
		logic signed [12:0] ex;
		logic signed [12:0] ke;
		logic signed [13:0] t;
		logic [7:0]         q;
		begin
			kx = 13'(k);
			ex = 13'(e);
			ke = kx * ex;
			t  = 14'(ke) + $signed({2'b00, v, 4'b0000});
			if (t[13]) begin
				q = 8'd0;
			end else if (t[12]) begin
				q = 8'hFF;
			end else begin
				q = t[11:4];
			end
			return q;
		end
	endfunction

endpackage

@@ rtl/pdith_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pdith_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ rtl/pdith_ctrl.sv @@
// Controller state machine sequencing loads, row reads, search, writes, emits and row copy.
`timescale 1ns / 1ps
module pdith_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  pdith_pkg::status_t st,
	output pdith_pkg::cmd_t    cmd
);
	pdith_pkg::state_t state_q;
	pdith_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdith_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pdith_pkg::S_IDLE: begin
				if (in_valid) state_d = pdith_pkg::S_DEC;
			end
			pdith_pkg::S_DEC: begin
				case (st.op)
					pdith_pkg::OP_LOAD:  state_d = st.idx_ok ? pdith_pkg::S_PAL : pdith_pkg::S_IDLE;
					pdith_pkg::OP_PIXEL: state_d = st.act ? pdith_pkg::S_RD0 : pdith_pkg::S_W2;
					pdith_pkg::OP_FLUSH: state_d = st.first ? pdith_pkg::S_IDLE : pdith_pkg::S_FRD;
					default:             state_d = pdith_pkg::S_IDLE;
				endcase
			end
			pdith_pkg::S_PAL:  state_d = pdith_pkg::S_IDLE;
			pdith_pkg::S_RD0:  state_d = pdith_pkg::S_RD1;
			pdith_pkg::S_RD1:  state_d = pdith_pkg::S_RD2;
			pdith_pkg::S_RD2:  state_d = st.quant ? pdith_pkg::S_SRCH : pdith_pkg::S_W2;
			pdith_pkg::S_SRCH: begin
				if (st.srch_done) state_d = pdith_pkg::S_W0;
			end
			pdith_pkg::S_W0:   state_d = pdith_pkg::S_W1;
			pdith_pkg::S_W1:   state_d = pdith_pkg::S_W2;
			pdith_pkg::S_W2: begin
				if (st.act) state_d = pdith_pkg::S_EMA;
				else if (st.last) state_d = pdith_pkg::S_COPY;
				else state_d = pdith_pkg::S_IDLE;
			end
			pdith_pkg::S_FRD:  state_d = pdith_pkg::S_FCAP;
			pdith_pkg::S_FCAP: state_d = pdith_pkg::S_EMA;
			pdith_pkg::S_EMA: begin
				if (out_ready) begin
					if (st.op == pdith_pkg::OP_PIXEL && st.last) state_d = pdith_pkg::S_EMB;
					else state_d = pdith_pkg::S_IDLE;
				end
			end
			pdith_pkg::S_EMB: begin
				if (out_ready) state_d = pdith_pkg::S_COPY;
			end
			pdith_pkg::S_COPY: begin
				if (st.copy_done) state_d = pdith_pkg::S_IDLE;
			end
			default: state_d = pdith_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			pdith_pkg::S_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
			end
			pdith_pkg::S_PAL:  cmd.pal_we = 1'b1;
			pdith_pkg::S_RD0:  cmd.rd_phase = pdith_pkg::RDP_A;
			pdith_pkg::S_RD1: begin
				cmd.rd_phase = pdith_pkg::RDP_B;
				cmd.cap_a    = 1'b1;
			end
			pdith_pkg::S_RD2: begin
				cmd.cap_b      = 1'b1;
				cmd.srch_start = 1'b1;
			end
			pdith_pkg::S_SRCH: cmd.srch_run = 1'b1;
			pdith_pkg::S_W0:   cmd.wr_phase = pdith_pkg::WRP_0;
			pdith_pkg::S_W1:   cmd.wr_phase = pdith_pkg::WRP_1;
			pdith_pkg::S_W2: begin
				cmd.wr_phase   = pdith_pkg::WRP_2;
				cmd.copy_start = 1'b1;
			end
			pdith_pkg::S_FRD:  cmd.rd_phase = pdith_pkg::RDP_F;
			pdith_pkg::S_FCAP: cmd.cap_f = 1'b1;
			pdith_pkg::S_EMA:  out_valid = 1'b1;
			pdith_pkg::S_EMB: begin
				out_valid      = 1'b1;
				cmd.out_b      = 1'b1;
				cmd.copy_start = 1'b1;
			end
			pdith_pkg::S_COPY: cmd.copy_run = 1'b1;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end
endmodule

@@ rtl/pdith_dp.sv @@
// Datapath: item latch, row and palette memories, nearest-entry search, error spread, row copy.
`timescale 1ns / 1ps
module pdith_dp #(
	parameter int MAX_WIDTH     = 1024,
	parameter int PALETTE_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pdith_pkg::cmd_t                     cmd,
	output pdith_pkg::status_t                  st,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]      w,
	input  logic [$clog2(PALETTE_DEPTH+1)-1:0]  n,
	input  logic [1:0]                          opcode,
	input  logic [3:0]                          entry_index,
	input  logic [7:0]                          red,
	input  logic [7:0]                          green,
	input  logic [7:0]                          blue,
	output logic [7:0]                          out_red,
	output logic [7:0]                          out_green,
	output logic [7:0]                          out_blue,
	output logic                                last_of_run,
	output logic                                frame_end
);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int NW = $clog2(PALETTE_DEPTH + 1);
	localparam int PW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	logic [CW-1:0]    col_q;
	logic             first_q;
	pdith_pkg::op_t   op_q;
	logic [3:0]       idx_q;
	logic             idx_ok_q;
	logic [23:0]      rgb_q;
	logic [CW-1:0]    c_q;
	logic             last_q;
	logic             fr_q;
	logic [23:0]      old_q;
	logic [23:0]      l3_q;
	logic [23:0]      r7_q;
	logic [23:0]      l5_q;
	logic [23:0]      best_q;
	logic [18:0]      best_d_q;
	logic [NW-1:0]    k_q;
	logic             cand_v_s1;
	logic [WW-1:0]    j_q;
	logic [CW-1:0]    j_s1;
	logic             cp_v_s1;
	logic [WW-1:0]    hw_q;

	logic             last_now;
	logic [CW-1:0]    x_a;
	logic [CW-1:0]    xm_a;
	logic             act;
	logic             quant;
	logic [23:0]      up_rd;
	logic [23:0]      lo_rd;
	logic [23:0]      pal_rd;
	logic             up_we;
	logic [CW-1:0]    up_wa;
	logic [23:0]      up_wd;
	logic [CW-1:0]    up_ra;
	logic             lo_we;
	logic [CW-1:0]    lo_wa;
	logic [23:0]      lo_wd;
	logic [CW-1:0]    lo_ra;
	logic [17:0]      sq_dist;
	logic [23:0]      s7_w;
	logic [23:0]      s5_w;
	logic [23:0]      s3_w;
	logic [23:0]      s1_w;
	logic [23:0]      emit_a;
	logic [23:0]      emit_b;
	logic [23:0]      emit;

	assign last_now = WW'(col_q) >= (w - WW'(1));
	assign x_a      = c_q - CW'(1);
	assign xm_a     = c_q - CW'(2);
	assign act      = (op_q == pdith_pkg::OP_PIXEL) && !fr_q && (c_q != '0);
	assign quant    = act && (c_q >= CW'(2)) && (WW'(c_q) <= (w - WW'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			first_q <= 1'b1;
		end else if (cmd.latch) begin
			if (opcode == pdith_pkg::OP_PIXEL) begin
				if (last_now) begin
					col_q   <= '0;
					first_q <= 1'b0;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else if (opcode == pdith_pkg::OP_FLUSH && !first_q) begin
				if (last_now) begin
					col_q   <= '0;
					first_q <= 1'b1;
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q     <= pdith_pkg::op_t'(opcode);
			idx_q    <= entry_index;
			idx_ok_q <= 32'(entry_index) < PALETTE_DEPTH;
			rgb_q    <= {red, green, blue};
			c_q      <= col_q;
			last_q   <= last_now;
			fr_q     <= first_q;
		end
		if (cmd.cap_a) begin
			old_q <= up_rd;
			l3_q  <= lo_rd;
		end
		if (cmd.cap_b) begin
			r7_q <= up_rd;
			l5_q <= lo_rd;
		end
		if (cmd.cap_f) begin
			old_q <= up_rd;
		end
	end

	always_comb begin
		logic signed [8:0]  df [3];
		logic signed [17:0] dx;
		logic [15:0]        sq [3];
		for (int i = 0; i < 3; i++) begin
			df[i] = $signed({1'b0, pal_rd[8*i +: 8]}) - $signed({1'b0, old_q[8*i +: 8]});
			dx    = 18'(df[i]);
			sq[i] = 16'(dx * dx);
		end
		sq_dist = 18'(sq[0]) + 18'(sq[1]) + 18'(sq[2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= '0;
			cand_v_s1 <= 1'b0;
		end else if (cmd.srch_start) begin
			k_q       <= '0;
			cand_v_s1 <= 1'b0;
		end else if (cmd.srch_run && k_q < n) begin
			k_q       <= k_q + NW'(1);
			cand_v_s1 <= 1'b1;
		end else begin
			cand_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.srch_start) begin
			best_d_q <= pdith_pkg::DIST_INIT;
		end else if (cand_v_s1 && ({1'b0, sq_dist} < best_d_q)) begin
			best_d_q <= {1'b0, sq_dist};
			best_q   <= pal_rd;
		end
	end

	always_comb begin
		logic signed [8:0] e;
		s7_w = '0;
		s5_w = '0;
		s3_w = '0;
		s1_w = '0;
		for (int i = 0; i < 3; i++) begin
			e = $signed({1'b0, old_q[8*i +: 8]}) - $signed({1'b0, best_q[8*i +: 8]});
			s7_w[8*i +: 8] = pdith_pkg::spread(r7_q[8*i +: 8], 3'd7, e);
			s5_w[8*i +: 8] = pdith_pkg::spread(l5_q[8*i +: 8], 3'd5, e);
			s3_w[8*i +: 8] = pdith_pkg::spread(l3_q[8*i +: 8], 3'd3, e);
			s1_w[8*i +: 8] = pdith_pkg::spread(rgb_q[8*i +: 8], 3'd1, e);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= '0;
		end else if (cmd.wr_phase == pdith_pkg::WRP_2 && WW'(c_q) >= hw_q) begin
			hw_q <= WW'(c_q) + WW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q     <= '0;
			cp_v_s1 <= 1'b0;
		end else if (cmd.copy_start) begin
			j_q     <= '0;
			cp_v_s1 <= 1'b0;
		end else if (cmd.copy_run && j_q < hw_q) begin
			j_q     <= j_q + WW'(1);
			cp_v_s1 <= 1'b1;
		end else begin
			cp_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= j_q[CW-1:0];
	end

	always_comb begin
		case (cmd.rd_phase)
			pdith_pkg::RDP_A: begin
				up_ra = x_a;
				lo_ra = xm_a;
			end
			pdith_pkg::RDP_B: begin
				up_ra = c_q;
				lo_ra = x_a;
			end
			pdith_pkg::RDP_F: begin
				up_ra = c_q;
				lo_ra = x_a;
			end
			default: begin
				up_ra = x_a;
				lo_ra = j_q[CW-1:0];
			end
		endcase
	end

	always_comb begin
		up_we = 1'b0;
		up_wa = x_a;
		up_wd = best_q;
		lo_we = 1'b0;
		lo_wa = c_q;
		lo_wd = rgb_q;
		case (cmd.wr_phase)
			pdith_pkg::WRP_0: begin
				up_we = 1'b1;
				up_wa = x_a;
				up_wd = best_q;
				lo_we = 1'b1;
				lo_wa = xm_a;
				lo_wd = s3_w;
			end
			pdith_pkg::WRP_1: begin
				up_we = 1'b1;
				up_wa = c_q;
				up_wd = s7_w;
				lo_we = 1'b1;
				lo_wa = x_a;
				lo_wd = s5_w;
			end
			pdith_pkg::WRP_2: begin
				lo_we = 1'b1;
				lo_wa = c_q;
				lo_wd = quant ? s1_w : rgb_q;
			end
			default: begin
				if (cp_v_s1) begin
					up_we = 1'b1;
					up_wa = j_s1;
					up_wd = lo_rd;
				end
			end
		endcase
	end

	pdith_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (up_we),
		.waddr (up_wa),
		.wdata (up_wd),
		.raddr (up_ra),
		.rdata (up_rd)
	);

	pdith_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_lower (
		.clk   (clk),
		.we    (lo_we),
		.waddr (lo_wa),
		.wdata (lo_wd),
		.raddr (lo_ra),
		.rdata (lo_rd)
	);

	pdith_ram #(.WIDTH(24), .DEPTH(PALETTE_DEPTH)) u_palette (
		.clk   (clk),
		.we    (cmd.pal_we),
		.waddr (PW'(idx_q)),
		.wdata (rgb_q),
		.raddr (k_q[PW-1:0]),
		.rdata (pal_rd)
	);

	assign emit_a = quant ? best_q : old_q;
	assign emit_b = quant ? s7_w : r7_q;
	assign emit   = cmd.out_b ? emit_b : emit_a;

	assign out_red     = emit[23:16];
	assign out_green   = emit[15:8];
	assign out_blue    = emit[7:0];
	assign last_of_run = cmd.out_b || (op_q == pdith_pkg::OP_FLUSH) || !last_q;
	assign frame_end   = !cmd.out_b && (op_q == pdith_pkg::OP_FLUSH) && last_q;

	assign st.op        = op_q;
	assign st.first     = fr_q;
	assign st.act       = act;
	assign st.quant     = quant;
	assign st.last      = last_q;
	assign st.idx_ok    = idx_ok_q;
	assign st.srch_done = (k_q >= n) && !cand_v_s1;
	assign st.copy_done = (j_q >= hw_q) && !cp_v_s1;

`ifndef SYNTHESIS
	a_copy_addr: assert property (@(posedge clk) disable iff (!arst_n)
		cp_v_s1 |-> (WW'(j_s1) < hw_q))
		else $error("row copy wrote beyond the written columns");
	a_first_set: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(first_q) |-> $past(cmd.latch && opcode == pdith_pkg::OP_FLUSH))
		else $error("frame start flag set without a flush item");
	a_first_clr: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(first_q) |-> $past(cmd.latch && opcode == pdith_pkg::OP_PIXEL))
		else $error("frame start flag cleared without a pixel item");
	a_srch_cand: assert property (@(posedge clk) disable iff (!arst_n)
		cand_v_s1 |-> (k_q != '0))
		else $error("search candidate without an issued entry");
`endif
endmodule

@@ rtl/palette_error_diffusion_dither_unit.sv @@
// Top level: configuration registers, controller and datapath of the palette dither unit.
// Sequence: a palette load passes decode and palette write; a pixel without quantization passes
// decode, the row reads and the row writes before its result; a quantized pixel also waits for
// the palette search, reading one entry per cycle from the palette memory.
// Throughput: one item at a time; the last pixel of a row then copies the first W columns of the
// arriving row into the finishing row, W being one past the highest column written since reset.
// Reset: asynchronous, active low; column zero, first-row flag set, registers 640 and 16.
`timescale 1ns / 1ps
module palette_error_diffusion_dither_unit #(
	parameter int MAX_WIDTH     = 1024,
	parameter int PALETTE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [3:0]  entry_index,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        last_of_run,
	output logic        frame_end
);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int NW = $clog2(PALETTE_DEPTH + 1);

	logic [pdith_pkg::RW_BITS-1:0] row_width_q;
	logic [pdith_pkg::PS_BITS-1:0] pal_size_q;
	logic [31:0]                   rw32;
	logic [31:0]                   ps32;
	logic [WW-1:0]                 w;
	logic [NW-1:0]                 n;
	pdith_pkg::cmd_t               cmd;
	pdith_pkg::status_t            st;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= pdith_pkg::ROW_WIDTH_RST;
			pal_size_q  <= pdith_pkg::PAL_SIZE_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == pdith_pkg::REG_ROW_WIDTH) begin
				row_width_q <= pwdata[pdith_pkg::RW_BITS-1:0];
			end else begin
				pal_size_q <= pwdata[pdith_pkg::PS_BITS-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == pdith_pkg::REG_ROW_WIDTH) ? 32'(row_width_q) : 32'(pal_size_q);

	assign rw32 = 32'(row_width_q);
	assign ps32 = 32'(pal_size_q);
	assign w = (rw32 < 32'd3) ? WW'(3) : (rw32 > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(rw32);
	assign n = (ps32 < 32'd1) ? NW'(1) :
		(ps32 > 32'(PALETTE_DEPTH)) ? NW'(PALETTE_DEPTH) : NW'(ps32);

	pdith_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	pdith_dp #(.MAX_WIDTH(MAX_WIDTH), .PALETTE_DEPTH(PALETTE_DEPTH)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.w           (w),
		.n           (n),
		.opcode      (opcode),
		.entry_index (entry_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_red     (out_red),
		.out_green   (out_green),
		.out_blue    (out_blue),
		.last_of_run (last_of_run),
		.frame_end   (frame_end)
	);
endmodule
